@@ rtl/core/poisson_spike_generator_top_macros.svh @@
// Assertion helpers for the core (included by psg_walker)
`ifndef POISSON_SPIKE_GENERATOR_TOP_MACROS_SVH
`define POISSON_SPIKE_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define PSG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PSG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/psg_pkg.sv @@
package psg_pkg;

   localparam int unsigned NEURONS      = 64;
   localparam int unsigned MT_N         = 624;
   localparam int unsigned MT_M         = 397;
   localparam logic [31:0] MT_INIT_MULT = 32'd1812433253;
   localparam logic [31:0] MT_MATRIX    = 32'h9908b0df;
   localparam logic [31:0] LN2_Q32      = 32'd2977044472;
   localparam logic [31:0] RESET_SEED   = 32'd620349123;
   localparam logic [31:0] RESET_SCALE  = 32'd65536;
   localparam int unsigned TICK_QUEUE_DEPTH = 2;

   // register index on the csr port
   typedef enum logic [1:0] {
      REG_SEED  = 2'd0,
      REG_SCALE = 2'd1,
      REG_RATE0 = 2'd2,
      REG_NEUR  = 2'd3
   } reg_index_type;

   // interval draw request: halves is 1 for the first position, 3 for steps
   typedef struct packed {
      logic       req;
      logic [1:0] halves;
   } draw_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] step;
   } draw_rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] word;
   } word_rsp_type;

   function automatic logic [31:0] temper(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x >> 11);
      y = y ^ ((y << 7) & 32'h9d2c5680);
      y = y ^ ((y << 15) & 32'hefc60000);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

@@ rtl/core/poisson_spike_generator_top.sv @@
// Poisson spike generator. Each accepted request word with tick set is one time bin; for that
// bin the block walks a position over a group of neurons_in_use neurons and sends one response
// word per spiking neuron (index in tdata, tuser set), tlast on the final word of the bin. A bin
// without spikes, or any bin while rate_zero is set, gives one word with tuser clear and tlast
// set. Request words with tick clear are taken and dropped. Intervals come from a 624-word
// twister whose output feeds a fixed-point -ln and a multiply by interval_scale. After reset,
// and after each seed write, the twister table is rebuilt; every 624 draws it is regenerated.
// One spike costs one interval draw, which includes a leading-one scan of the random word.
// A scale write draws a new first position, one more interval. Up to two bins queue at the
// input while the back end works or waits on the response side.
module poisson_spike_generator_top #(
   parameter int unsigned LOG_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [0] tick
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [5:0] neuron_index
   output logic        rsp_tuser,    // spike_valid
   output logic        rsp_tlast,    // last_of_tick
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0] seed_ff, seed_in;
   logic [31:0] scale_ff, scale_in;
   logic        rz_ff, rz_in;
   logic [6:0]  neur_ff, neur_in;

   logic        csr_wr;
   logic        seed_wr;
   logic        scale_wr;
   psg_pkg::reg_index_type csr_idx;

   logic                  tick_avail;
   logic                  tick_pop;
   psg_pkg::draw_req_type draw_req;
   psg_pkg::draw_rsp_type draw_rsp;
   logic                  word_req;
   psg_pkg::word_rsp_type word_rsp;

   // register file: index from paddr[3:2], writes land on the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = psg_pkg::reg_index_type'(csr_paddr[3:2]);
   assign seed_wr    = csr_wr && (csr_idx == psg_pkg::REG_SEED);
   assign scale_wr   = csr_wr && (csr_idx == psg_pkg::REG_SCALE);

   always_comb begin
      seed_in  = seed_ff;
      scale_in = scale_ff;
      rz_in    = rz_ff;
      neur_in  = neur_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            psg_pkg::REG_SEED:  seed_in  = csr_pwdata;
            psg_pkg::REG_SCALE: scale_in = csr_pwdata;
            psg_pkg::REG_RATE0: rz_in    = csr_pwdata[0];
            psg_pkg::REG_NEUR:  neur_in  = csr_pwdata[6:0];
            default:            seed_in  = seed_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         psg_pkg::REG_SEED:  csr_prdata = seed_ff;
         psg_pkg::REG_SCALE: csr_prdata = scale_ff;
         psg_pkg::REG_RATE0: csr_prdata = {31'd0, rz_ff};
         psg_pkg::REG_NEUR:  csr_prdata = {25'd0, neur_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= psg_pkg::RESET_SEED;
         scale_ff <= psg_pkg::RESET_SCALE;
         rz_ff    <= 1'b0;
         neur_ff  <= 7'(psg_pkg::NEURONS);
      end else begin
         seed_ff  <= seed_in;
         scale_ff <= scale_in;
         rz_ff    <= rz_in;
         neur_ff  <= neur_in;
      end
   end

   // front end: takes request words, keeps a count of pending bins
   psg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .tick_avail (tick_avail),
      .tick_pop   (tick_pop)
   );

   // back end: position walk and response register
   psg_walker u_walker (
      .clock          (clock),
      .reset          (reset),
      .tick_avail     (tick_avail),
      .tick_pop       (tick_pop),
      .rate_zero      (rz_ff),
      .neurons_in_use (neur_ff),
      .redraw_start   (scale_wr),
      .draw_req       (draw_req),
      .draw_rsp       (draw_rsp),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast)
   );

   // interval unit: -ln in fixed point times scale
   psg_interval #(
      .LOG_FRAC_BITS (LOG_FRAC_BITS)
   ) u_interval (
      .clock    (clock),
      .reset    (reset),
      .draw_req (draw_req),
      .scale    (scale_ff),
      .draw_rsp (draw_rsp),
      .word_req (word_req),
      .word_rsp (word_rsp)
   );

   // random source; a seed write queues a table rebuild
   psg_twister u_twister (
      .clock      (clock),
      .reset      (reset),
      .init_start (seed_wr),
      .seed       (seed_ff),
      .word_req   (word_req),
      .word_rsp   (word_rsp)
   );

endmodule

@@ rtl/core/psg_twister.sv @@
module psg_twister (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    init_start,
   input  logic [31:0]             seed,
   input  logic                    word_req,
   output psg_pkg::word_rsp_type   word_rsp
);

   typedef enum logic [9:0] {
      T_IDLE     = 10'b0000000001,
      T_INIT_MUL = 10'b0000000010,
      T_INIT_WR  = 10'b0000000100,
      T_G_L0     = 10'b0000001000,
      T_G_L1     = 10'b0000010000,
      T_G_R1     = 10'b0000100000,
      T_G_R2     = 10'b0001000000,
      T_G_WR     = 10'b0010000000,
      T_FETCH    = 10'b0100000000,
      T_TEMPER   = 10'b1000000000
   } tw_state_type;

   localparam logic [9:0]  LAST_IDX = 10'(psg_pkg::MT_N - 1);
   localparam logic [9:0]  FULL_IDX = 10'(psg_pkg::MT_N);

   tw_state_type state_ff, state_in;
   logic [9:0]   idx_ff, idx_in;
   logic [9:0]   i_ff, i_in;
   logic [31:0]  p_ff, p_in;
   logic [31:0]  prod_ff, prod_in;
   logic [31:0]  cur_ff, cur_in;
   logic [31:0]  nxt_ff, nxt_in;
   logic         pend_ff, pend_in;

   logic [31:0]  mem [psg_pkg::MT_N];
   logic [31:0]  rd_data_ff;
   logic [9:0]   rd_addr;
   logic         wr_en;
   logic [9:0]   wr_addr;
   logic [31:0]  wr_data;

   logic [9:0]   i_plus1;
   logic [10:0]  sum_m;
   logic [9:0]   i_plusm;
   logic [31:0]  y_mix;
   logic [31:0]  init_word;

   assign i_plus1   = (i_ff == LAST_IDX) ? 10'd0 : i_ff + 10'd1;
   assign sum_m     = {1'b0, i_ff} + 11'(psg_pkg::MT_M);
   assign i_plusm   = (sum_m >= 11'(psg_pkg::MT_N)) ? 10'(sum_m - 11'(psg_pkg::MT_N))
                                                     : sum_m[9:0];
   assign y_mix     = {cur_ff[31], nxt_ff[30:0]};
   assign init_word = prod_ff + {22'd0, i_ff};

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      i_in     = i_ff;
      p_in     = p_ff;
      prod_in  = prod_ff;
      cur_in   = cur_ff;
      nxt_in   = nxt_ff;
      pend_in  = pend_ff | init_start;
      rd_addr  = 10'd0;
      wr_en    = 1'b0;
      wr_addr  = i_ff;
      wr_data  = init_word;
      word_rsp = '{valid: 1'b0, word: psg_pkg::temper(rd_data_ff)};
      unique case (state_ff)
         T_IDLE: begin
            if (pend_ff) begin
               // word 0 is the seed itself
               wr_en    = 1'b1;
               wr_addr  = 10'd0;
               wr_data  = seed;
               p_in     = seed;
               i_in     = 10'd1;
               pend_in  = init_start;
               state_in = T_INIT_MUL;
            end else if (word_req) begin
               if (idx_ff >= FULL_IDX) begin
                  i_in     = 10'd0;
                  state_in = T_G_L0;
               end else begin
                  state_in = T_FETCH;
               end
            end
         end
         T_INIT_MUL: begin
            prod_in  = 32'(psg_pkg::MT_INIT_MULT * (p_ff ^ (p_ff >> 30)));
            state_in = T_INIT_WR;
         end
         T_INIT_WR: begin
            wr_en = 1'b1;
            p_in  = init_word;
            if (i_ff == LAST_IDX) begin
               idx_in   = FULL_IDX;
               state_in = T_IDLE;
            end else begin
               i_in     = i_ff + 10'd1;
               state_in = T_INIT_MUL;
            end
         end
         T_G_L0: begin
            rd_addr  = 10'd0;
            state_in = T_G_L1;
         end
         T_G_L1: begin
            cur_in   = rd_data_ff;
            rd_addr  = i_plus1;
            state_in = T_G_R2;
         end
         T_G_R1: begin
            rd_addr  = i_plus1;
            state_in = T_G_R2;
         end
         T_G_R2: begin
            nxt_in   = rd_data_ff;
            rd_addr  = i_plusm;
            state_in = T_G_WR;
         end
         T_G_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data_ff ^ (y_mix >> 1) ^ (y_mix[0] ? psg_pkg::MT_MATRIX : 32'd0);
            cur_in  = nxt_ff;
            if (i_ff == LAST_IDX) begin
               idx_in   = 10'd0;
               state_in = T_FETCH;
            end else begin
               i_in     = i_ff + 10'd1;
               state_in = T_G_R1;
            end
         end
         T_FETCH: begin
            rd_addr  = idx_ff;
            state_in = T_TEMPER;
         end
         T_TEMPER: begin
            word_rsp.valid = 1'b1;
            idx_in         = idx_ff + 10'd1;
            state_in       = T_IDLE;
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         idx_ff   <= FULL_IDX;
         pend_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
      end
      i_ff    <= i_in;
      p_ff    <= p_in;
      prod_ff <= prod_in;
      cur_ff  <= cur_in;
      nxt_ff  <= nxt_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

@@ rtl/core/psg_interval.sv @@
module psg_interval #(
   parameter int unsigned LOG_FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  psg_pkg::draw_req_type   draw_req,
   input  logic [31:0]             scale,
   output psg_pkg::draw_rsp_type   draw_rsp,
   output logic                    word_req,
   input  psg_pkg::word_rsp_type   word_rsp
);

   localparam int unsigned F  = LOG_FRAC_BITS;
   localparam int unsigned TW = F + 6;
   localparam int unsigned PW = TW + 32;
   localparam int unsigned KW = $clog2(F);
   localparam logic [TW-1:0] T_FULL = TW'(32) << F;
   localparam logic [KW-1:0] K_LAST = KW'(F - 1);

   typedef enum logic [9:0] {
      I_IDLE  = 10'b0000000001,
      I_FETCH = 10'b0000000010,
      I_NORM  = 10'b0000000100,
      I_SQ    = 10'b0000001000,
      I_SQCHK = 10'b0000010000,
      I_LN    = 10'b0000100000,
      I_LNRND = 10'b0001000000,
      I_SCALE = 10'b0010000000,
      I_SUM   = 10'b0100000000,
      I_DONE  = 10'b1000000000
   } itv_state_type;

   itv_state_type   state_ff, state_in;
   logic [31:0]     m_ff, m_in;
   logic [4:0]      e_ff, e_in;
   logic [F-1:0]    frac_ff, frac_in;
   logic [KW-1:0]   k_ff, k_in;
   logic [63:0]     sq_ff, sq_in;
   logic [PW-1:0]   lnp_ff, lnp_in;
   logic [TW-1:0]   nl_ff, nl_in;
   logic [PW-1:0]   prod_ff, prod_in;
   logic [31:0]     step_ff, step_in;
   logic [1:0]      halves_ff, halves_in;

   logic [32:0]     sq_top;
   logic [PW:0]     ln_round;
   logic [PW:0]     sum_full;

   assign sq_top   = sq_ff[63:31];
   assign ln_round = {1'b0, lnp_ff} + (PW + 1)'(33'h080000000);
   assign sum_full = {1'b0, prod_ff} + ((PW + 1)'(halves_ff) << (F + 15));
   assign draw_rsp = '{done: (state_ff == I_DONE), step: step_ff};
   assign word_req = (state_ff == I_FETCH);

   always_comb begin
      state_in  = state_ff;
      m_in      = m_ff;
      e_in      = e_ff;
      frac_in   = frac_ff;
      k_in      = k_ff;
      sq_in     = sq_ff;
      lnp_in    = lnp_ff;
      nl_in     = nl_ff;
      prod_in   = prod_ff;
      step_in   = step_ff;
      halves_in = halves_ff;
      unique case (state_ff)
         I_IDLE: begin
            if (draw_req.req) begin
               halves_in = draw_req.halves;
               state_in  = I_FETCH;
            end
         end
         I_FETCH: begin
            if (word_rsp.valid) begin
               // zero word counts as one
               m_in     = (word_rsp.word == 32'd0) ? 32'd1 : word_rsp.word;
               e_in     = 5'd31;
               state_in = I_NORM;
            end
         end
         I_NORM: begin
            // one bit per cycle toward the leading one
            if (m_ff[31]) begin
               k_in     = '0;
               frac_in  = '0;
               state_in = I_SQ;
            end else begin
               m_in = m_ff << 1;
               e_in = e_ff - 5'd1;
            end
         end
         I_SQ: begin
            sq_in    = 64'(m_ff) * 64'(m_ff);
            state_in = I_SQCHK;
         end
         I_SQCHK: begin
            frac_in = {frac_ff[F-2:0], sq_top[32]};
            m_in    = sq_top[32] ? sq_top[32:1] : sq_top[31:0];
            k_in    = k_ff + KW'(1);
            state_in = (k_ff == K_LAST) ? I_LN : I_SQ;
         end
         I_LN: begin
            lnp_in   = PW'(T_FULL - TW'({e_ff, frac_ff})) * PW'(psg_pkg::LN2_Q32);
            state_in = I_LNRND;
         end
         I_LNRND: begin
            nl_in    = ln_round[32 +: TW];
            state_in = I_SCALE;
         end
         I_SCALE: begin
            prod_in  = PW'(nl_ff) * PW'(scale);
            state_in = I_SUM;
         end
         I_SUM: begin
            // product stays below 2^32 bins after the shift
            step_in  = 32'(sum_full >> (F + 16));
            state_in = I_DONE;
         end
         I_DONE: begin
            state_in = I_IDLE;
         end
         default: begin
            state_in = I_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= I_IDLE;
      end else begin
         state_ff <= state_in;
      end
      m_ff      <= m_in;
      e_ff      <= e_in;
      frac_ff   <= frac_in;
      k_ff      <= k_in;
      sq_ff     <= sq_in;
      lnp_ff    <= lnp_in;
      nl_ff     <= nl_in;
      prod_ff   <= prod_in;
      step_ff   <= step_in;
      halves_ff <= halves_in;
   end

endmodule

@@ rtl/core/psg_front.sv @@
module psg_front (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [0] tick
   output logic       tick_avail,
   input  logic       tick_pop
);

   localparam int unsigned CW = $clog2(psg_pkg::TICK_QUEUE_DEPTH + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          push;

   // words with tick low are taken and dropped
   assign req_tready = (cnt_ff != CW'(psg_pkg::TICK_QUEUE_DEPTH));
   assign push       = req_tvalid & req_tready & req_tdata[0];
   assign tick_avail = (cnt_ff != '0);

   always_comb begin
      cnt_in = cnt_ff;
      case ({push, tick_pop})
         2'b10:   cnt_in = cnt_ff + CW'(1);
         2'b01:   cnt_in = cnt_ff - CW'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ rtl/core/psg_walker.sv @@
`include "poisson_spike_generator_top_macros.svh"

module psg_walker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    tick_avail,
   output logic                    tick_pop,
   input  logic                    rate_zero,
   input  logic [6:0]              neurons_in_use,
   input  logic                    redraw_start,
   output psg_pkg::draw_req_type   draw_req,
   input  psg_pkg::draw_rsp_type   draw_rsp,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,  // [5:0] neuron_index
   output logic                    rsp_tuser,  // spike_valid
   output logic                    rsp_tlast   // last_of_tick
);

   typedef enum logic [5:0] {
      W_IDLE   = 6'b000001,
      W_REDRAW = 6'b000010,
      W_CHECK  = 6'b000100,
      W_DRAW   = 6'b001000,
      W_EMIT   = 6'b010000,
      W_EMPTY  = 6'b100000
   } walk_state_type;

   walk_state_type state_ff, state_in;
   logic [31:0]    pos_ff, pos_in;
   logic           redraw_ff, redraw_in;
   logic [6:0]     n_ff, n_in;
   logic           rz_ff, rz_in;
   logic [5:0]     idx_ff, idx_in;
   logic           out_valid_ff, out_valid_in;
   logic [5:0]     out_idx_ff, out_idx_in;
   logic           out_spike_ff, out_spike_in;
   logic           out_last_ff, out_last_in;

   logic           slot_free;
   logic           pos_in_group;
   logic [32:0]    pos_sum;
   logic [6:0]     n_eff;

   assign slot_free    = !out_valid_ff || rsp_tready;
   assign pos_in_group = (pos_ff < {25'd0, n_ff});
   assign pos_sum      = {1'b0, pos_ff} + {1'b0, draw_rsp.step};
   assign n_eff        = (neurons_in_use == 7'd0) ? 7'd1 :
                         (neurons_in_use > 7'(psg_pkg::NEURONS)) ? 7'(psg_pkg::NEURONS) :
                         neurons_in_use;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_idx_ff};
   assign rsp_tuser  = out_spike_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      redraw_in    = redraw_ff | redraw_start;
      n_in         = n_ff;
      rz_in        = rz_ff;
      idx_in       = idx_ff;
      tick_pop     = 1'b0;
      draw_req     = '{req: 1'b0, halves: 2'd3};
      out_valid_in = out_valid_ff && !rsp_tready;
      out_idx_in   = out_idx_ff;
      out_spike_in = out_spike_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         W_IDLE: begin
            if (redraw_ff) begin
               redraw_in = redraw_start;
               state_in  = W_REDRAW;
            end else if (tick_avail) begin
               tick_pop = 1'b1;
               n_in     = n_eff;
               rz_in    = rate_zero;
               state_in = rate_zero ? W_EMPTY : W_CHECK;
            end
         end
         W_REDRAW: begin
            draw_req = '{req: 1'b1, halves: 2'd1};
            if (draw_rsp.done) begin
               pos_in   = draw_rsp.step;
               state_in = W_IDLE;
            end
         end
         W_CHECK: begin
            if (pos_in_group) begin
               idx_in   = pos_ff[5:0];
               state_in = W_DRAW;
            end else begin
               state_in = W_EMPTY;
            end
         end
         W_DRAW: begin
            draw_req = '{req: 1'b1, halves: 2'd3};
            if (draw_rsp.done) begin
               pos_in   = pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];
               state_in = W_EMIT;
            end
         end
         W_EMIT: begin
            // the spike held in idx is last once the new position leaves the group
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_idx_in   = idx_ff;
               out_spike_in = 1'b1;
               out_last_in  = !pos_in_group;
               if (pos_in_group) begin
                  idx_in   = pos_ff[5:0];
                  state_in = W_DRAW;
               end else begin
                  pos_in   = pos_ff - {25'd0, n_ff};
                  state_in = W_IDLE;
               end
            end
         end
         W_EMPTY: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_idx_in   = 6'd0;
               out_spike_in = 1'b0;
               out_last_in  = 1'b1;
               if (!rz_ff) begin
                  pos_in = pos_ff - {25'd0, n_ff};
               end
               state_in = W_IDLE;
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= W_IDLE;
         redraw_ff    <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         redraw_ff    <= redraw_in;
         out_valid_ff <= out_valid_in;
      end
      pos_ff       <= pos_in;
      n_ff         <= n_in;
      rz_ff        <= rz_in;
      idx_ff       <= idx_in;
      out_idx_ff   <= out_idx_in;
      out_spike_ff <= out_spike_in;
      out_last_ff  <= out_last_in;
   end

   `PSG_ASSERT_IMP(a_empty_is_last, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast,
                   "empty word not marked last")
   `PSG_ASSERT_IMP(a_spike_in_group, clock, reset, rsp_tvalid && rsp_tuser,
                   7'(rsp_tdata[5:0]) < n_ff, "spike index outside group")
   `PSG_ASSERT_IMP(a_done_when_asked, clock, reset, draw_rsp.done,
                   state_ff == W_DRAW || state_ff == W_REDRAW, "interval done without request")
   `PSG_ASSERT_NEXT(a_emit_loads_slot, clock, reset, state_ff == W_EMIT && slot_free,
                    rsp_tvalid && rsp_tuser, "spike not presented")

endmodule
